// ----- src/sequence_reorder_buffer_macros.svh -----
// assertion macros shared by the reorder buffer rtl
`ifndef SEQUENCE_REORDER_BUFFER_MACROS_SVH
`define SEQUENCE_REORDER_BUFFER_MACROS_SVH

// condition must hold whenever out of reset
`define SRB_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define SRB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/srb_pkg.sv -----
`timescale 1ns / 1ps

package srb_pkg;

  // field widths
  localparam int SEQ_W = 32;
  localparam int LEN_W = 10;
  localparam int HDL_W = 16;

  // stash geometry and length limit
  localparam int STASH_DEPTH_DEF  = 16;
  localparam int MAX_PACKET_BYTES = 512;
  localparam int MAX_BYTES_W      = 13;

  // expected sequence number after reset
  localparam logic [SEQ_W-1:0] EXP_RESET = SEQ_W'(1);

  // data handed from cell to cell along the search chain
  typedef struct packed {
    logic             found;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [HDL_W-1:0] handle;
  } srb_chain_t;

  // clamp a length to the packet size limit, kept to the field width
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
    logic [MAX_BYTES_W-1:0] wide;
    logic [MAX_BYTES_W-1:0] lim;
    wide = MAX_BYTES_W'(len);
    lim  = MAX_BYTES_W'(MAX_PACKET_BYTES);
    if (wide > lim) begin
      return lim[LEN_W-1:0];
    end
    return len;
  endfunction

endpackage

// ----- src/srb_cell.sv -----
`timescale 1ns / 1ps

module srb_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [srb_pkg::SEQ_W-1:0]   exp_seq,
  input  logic                        wr_en,
  input  logic [srb_pkg::SEQ_W-1:0]   wr_seq,
  input  logic [srb_pkg::LEN_W-1:0]   wr_len,
  input  logic [srb_pkg::HDL_W-1:0]   wr_handle,
  input  logic                        take,
  input  srb_pkg::srb_chain_t         chain_in,
  output srb_pkg::srb_chain_t         chain_out,
  output logic                        grant
);

  logic [srb_pkg::SEQ_W-1:0] seq_r;
  logic [srb_pkg::LEN_W-1:0] len_r;
  logic [srb_pkg::HDL_W-1:0] handle_r;
  logic                      hit_r;

  // sequence slot, zero means empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
    end else if (wr_en) begin
      seq_r <= wr_seq;
    end else if (take && grant) begin
      seq_r <= '0;
    end
  end

  // length and handle, only read once written
  always_ff @(posedge clk) begin
    if (wr_en) begin
      len_r    <= wr_len;
      handle_r <= wr_handle;
    end
  end

  // registered match against the expected number
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= (seq_r != '0) && (seq_r == exp_seq);
    end
  end

  // lowest matching cell wins, later cells pass its data on
  assign grant = hit_r && !chain_in.found;

  always_comb begin
    chain_out       = chain_in;
    chain_out.found = chain_in.found || hit_r;
    if (grant) begin
      chain_out.seq    = seq_r;
      chain_out.len    = len_r;
      chain_out.handle = handle_r;
    end
  end

endmodule

// ----- src/sequence_reorder_buffer.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  seq_number, pkt_length, payload_handle
// out_      output     out_valid / out_stall seq, length, handle, from_stash, last
//
// an item that is dropped or stashed is taken while the sequencer stays idle
// an in-order item passes through S_CMP and S_SEL, and again for each stashed item it releases
// (S_CMP refreshes the per-cell match flags, S_SEL picks the lowest match)
// reset clears the stash sequence slots at once; no clearing pass
// a stalled output holds the drain until the output register frees up;
// a new item is taken while the last result still waits in that register

`include "sequence_reorder_buffer_macros.svh"

module sequence_reorder_buffer #(
  parameter int STASH_DEPTH = srb_pkg::STASH_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [srb_pkg::SEQ_W-1:0] in_seq_number,
  input  logic [srb_pkg::LEN_W-1:0] in_pkt_length,
  input  logic [srb_pkg::HDL_W-1:0] in_payload_handle,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [srb_pkg::SEQ_W-1:0] out_seq,
  output logic [srb_pkg::LEN_W-1:0] out_length,
  output logic [srb_pkg::HDL_W-1:0] out_handle,
  output logic                      out_from_stash,
  output logic                      out_last
);

  localparam int IDX_W = $clog2(STASH_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_SEL  = 3'b100
  } state_t;

  state_t                    state_r, state_nxt;
  logic [srb_pkg::SEQ_W-1:0] exp_r, exp_nxt;
  logic [IDX_W-1:0]          ws_r, ws_nxt;

  logic [srb_pkg::SEQ_W-1:0] pend_seq_r, pend_seq_nxt;
  logic [srb_pkg::LEN_W-1:0] pend_len_r, pend_len_nxt;
  logic [srb_pkg::HDL_W-1:0] pend_handle_r, pend_handle_nxt;
  logic                      pend_fs_r, pend_fs_nxt;

  logic                      out_valid_r;
  logic [srb_pkg::SEQ_W-1:0] out_seq_r;
  logic [srb_pkg::LEN_W-1:0] out_len_r;
  logic [srb_pkg::HDL_W-1:0] out_handle_r;
  logic                      out_fs_r;
  logic                      out_last_r;

  logic                      accept, is_eq, is_gt, stash_wr;
  logic                      out_take, out_free, emit, found, take;
  logic [srb_pkg::LEN_W-1:0] len_sat;
  logic [STASH_DEPTH-1:0]    grant_vec;
  srb_pkg::srb_chain_t       chain [STASH_DEPTH+1];

  // input decode
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_eq    = (in_seq_number == exp_r);
  assign is_gt    = (in_seq_number > exp_r);
  assign stash_wr = accept && is_gt;
  assign len_sat  = srb_pkg::sat_len(in_pkt_length);

  // output side
  assign out_take = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || out_take;
  assign emit     = (state_r == S_SEL) && out_free;
  assign found    = chain[STASH_DEPTH].found;
  assign take     = emit && found;

  // stash cells in a chain, lowest index searched first
  assign chain[0] = '0;

  for (genvar i = 0; i < STASH_DEPTH; i++) begin : g_cell
    srb_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .exp_seq   (exp_r),
      .wr_en     (stash_wr && (ws_r == IDX_W'(i))),
      .wr_seq    (in_seq_number),
      .wr_len    (len_sat),
      .wr_handle (in_payload_handle),
      .take      (take),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .grant     (grant_vec[i])
    );
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    exp_nxt         = exp_r;
    ws_nxt          = ws_r;
    pend_seq_nxt    = pend_seq_r;
    pend_len_nxt    = pend_len_r;
    pend_handle_nxt = pend_handle_r;
    pend_fs_nxt     = pend_fs_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && is_eq) begin
          pend_seq_nxt    = in_seq_number;
          pend_len_nxt    = len_sat;
          pend_handle_nxt = in_payload_handle;
          pend_fs_nxt     = 1'b0;
          exp_nxt         = exp_r + srb_pkg::SEQ_W'(1);
          state_nxt       = S_CMP;
        end else if (stash_wr) begin
          ws_nxt = (ws_r == IDX_W'(STASH_DEPTH - 1)) ? '0 : ws_r + IDX_W'(1);
        end
      end
      S_CMP: begin
        state_nxt = S_SEL;
      end
      S_SEL: begin
        if (emit) begin
          if (found) begin
            pend_seq_nxt    = chain[STASH_DEPTH].seq;
            pend_len_nxt    = chain[STASH_DEPTH].len;
            pend_handle_nxt = chain[STASH_DEPTH].handle;
            pend_fs_nxt     = 1'b1;
            exp_nxt         = exp_r + srb_pkg::SEQ_W'(1);
            state_nxt       = S_CMP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      exp_r       <= srb_pkg::EXP_RESET;
      ws_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      exp_r   <= exp_nxt;
      ws_r    <= ws_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pending delivery and output payload
  always_ff @(posedge clk) begin
    pend_seq_r    <= pend_seq_nxt;
    pend_len_r    <= pend_len_nxt;
    pend_handle_r <= pend_handle_nxt;
    pend_fs_r     <= pend_fs_nxt;
    if (emit) begin
      out_seq_r    <= pend_seq_r;
      out_len_r    <= pend_len_r;
      out_handle_r <= pend_handle_r;
      out_fs_r     <= pend_fs_r;
      out_last_r   <= !found;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_seq        = out_seq_r;
  assign out_length     = out_len_r;
  assign out_handle     = out_handle_r;
  assign out_from_stash = out_fs_r;
  assign out_last       = out_last_r;

  // checks
  `SRB_ASSERT_ALWAYS(a_grant_onehot0, clk, rst_n, $onehot0(grant_vec), "two cells granted")
  `SRB_ASSERT_IMP(a_idle_no_match, clk, rst_n, state_r == S_IDLE, !found, "stash match left undrained")
  `SRB_ASSERT_NEXT(a_drain_step, clk, rst_n, take, exp_r == $past(exp_r) + srb_pkg::SEQ_W'(1), "expected number not advanced on drain")
  `SRB_ASSERT_NEXT(a_last_ends, clk, rst_n, emit && !found, state_r == S_IDLE && out_last, "final item did not end the drain")

endmodule
